@@ rtl/pchrp_pkg.sv @@
package pchrp_pkg;

    localparam int IDX_BITS        = 11;
    localparam int TABLE_ENTRIES   = 1 << IDX_BITS;
    localparam int CTR_W           = 3;
    localparam int OUT_W           = 3;
    localparam int PC_W            = 64;
    localparam int HASH_STEPS      = 32;
    localparam int HASH_STAGES     = 4;
    localparam int STEPS_PER_STAGE = HASH_STEPS / HASH_STAGES;

    localparam logic [PC_W-1:0] CRC_POLY = 64'h0000_0000_EDB8_8320;

    typedef logic [CTR_W-1:0]    t_ctr;
    typedef logic [IDX_BITS-1:0] t_idx;

    localparam t_ctr CTR_MAX  = '1;
    localparam t_ctr CTR_HALF = t_ctr'(1 << (CTR_W - 1));

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic            valid;
        logic            op;
        logic            hit;
        logic [PC_W-1:0] h;
    } t_hash_stage;

    typedef struct packed {
        logic valid;
        logic op;
        logic hit;
        t_idx idx;
    } t_idx_stage;

    // one pipeline stage worth of reflected CRC shift steps
    function automatic logic [PC_W-1:0] crc_chunk(input logic [PC_W-1:0] h_in);
        logic [PC_W-1:0] h;
        h = h_in;
        for (int i = 0; i < STEPS_PER_STAGE; i++) begin
            h = h[0] ? ((h >> 1) ^ CRC_POLY) : (h >> 1);
        end
        return h;
    endfunction

    function automatic t_ctr ctr_update(input t_ctr c, input logic train, input logic hit);
        t_ctr r;
        r = c;
        if (train) begin
            if (hit) begin
                if (c != CTR_MAX) r = c + t_ctr'(1);
            end else begin
                if (c != '0) r = c - t_ctr'(1);
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/pchrp_if.sv @@
interface pchrp_in_if import pchrp_pkg::*;;
    logic            valid;
    logic            ready;
    logic            operation;
    logic [PC_W-1:0] pc;
    logic            opt_hit;

    modport source(output valid, output operation, output pc, output opt_hit, input ready);
    modport sink(input valid, input operation, input pc, input opt_hit, output ready);
endinterface

interface pchrp_out_if import pchrp_pkg::*;;
    logic             valid;
    logic             ready;
    logic             friendly;
    logic [OUT_W-1:0] counter_value;

    modport source(output valid, output friendly, output counter_value, input ready);
    modport sink(input valid, input friendly, input counter_value, output ready);
endinterface

@@ rtl/pc_hashed_reuse_predictor_top.sv @@
// PC-hashed reuse predictor. Each transfer on i_in carries a query or a training event for
// one instruction address; each gives one result on o_out with the indexed saturating
// counter after the update and its cache-friendly bit. One item per cycle is accepted while
// o_out is not stalled and no clearing pass runs; the pipeline has four hash stages (8 CRC
// steps each, the first feeding the first pipeline register), one counter memory read and one
// update/write-back stage feeding the output register. A stalled result freezes the whole
// pipeline. A one-entry bypass covers back-to-back items hitting the same counter. After
// reset a clearing pass writes each of the 2048 counters to half range; i_in.ready stays
// low until it completes.
module pc_hashed_reuse_predictor_top import pchrp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pchrp_in_if.sink     i_in,
    pchrp_out_if.source  o_out
);

    t_state r_state, n_state;
    t_idx   r_clr_idx;
    logic   w_clearing;

    t_hash_stage r_hs [HASH_STAGES-1];
    t_hash_stage w_hs_in;
    logic [PC_W-1:0] w_h_final;
    t_idx_stage  r_is;
    t_idx_stage  r_ms;

    t_ctr mem [TABLE_ENTRIES];
    t_ctr r_rd;
    logic r_byp;
    t_ctr r_byp_val;
    t_ctr w_cur;
    t_ctr w_new;

    logic w_we;
    t_idx w_waddr;
    t_ctr w_wdata;

    logic             r_out_valid;
    logic             r_out_friendly;
    logic [OUT_W-1:0] r_out_value;
    logic [CTR_W+OUT_W-1:0] w_ext;

    logic w_adv;

    // state machine
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_idx == '1) n_state = ST_RUN;
            end
            ST_RUN: n_state = ST_RUN;
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        case (r_state)
            ST_CLEAR: w_clearing = 1'b1;
            ST_RUN:   w_clearing = 1'b0;
            default:  w_clearing = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state <= n_state;
            if (w_clearing) r_clr_idx <= r_clr_idx + t_idx'(1);
        end
    end

    assign w_adv      = !r_out_valid || o_out.ready;
    assign i_in.ready = w_adv && !w_clearing;

    // hash pipeline
    always_comb begin
        w_hs_in.valid = i_in.valid && i_in.ready;
        w_hs_in.op    = i_in.operation;
        w_hs_in.hit   = i_in.opt_hit;
        w_hs_in.h     = crc_chunk(i_in.pc);
    end

    assign w_h_final = crc_chunk(r_hs[HASH_STAGES-2].h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HASH_STAGES - 1; i++) r_hs[i].valid <= 1'b0;
            r_is.valid <= 1'b0;
            r_ms.valid <= 1'b0;
        end else if (w_adv) begin
            r_hs[0] <= w_hs_in;
            for (int i = 1; i < HASH_STAGES - 1; i++) begin
                r_hs[i].valid <= r_hs[i-1].valid;
                r_hs[i].op    <= r_hs[i-1].op;
                r_hs[i].hit   <= r_hs[i-1].hit;
                r_hs[i].h     <= crc_chunk(r_hs[i-1].h);
            end
            r_is.valid <= r_hs[HASH_STAGES-2].valid;
            r_is.op    <= r_hs[HASH_STAGES-2].op;
            r_is.hit   <= r_hs[HASH_STAGES-2].hit;
            r_is.idx   <= w_h_final[IDX_BITS-1:0];
            r_ms       <= r_is;
        end
    end

    // counter memory, read-modify-write
    assign w_cur = r_byp ? r_byp_val : r_rd;
    assign w_new = ctr_update(w_cur, r_ms.op, r_ms.hit);

    always_comb begin
        if (w_clearing) begin
            w_we    = 1'b1;
            w_waddr = r_clr_idx;
            w_wdata = CTR_HALF;
        end else begin
            w_we    = w_adv && r_ms.valid && r_ms.op;
            w_waddr = r_ms.idx;
            w_wdata = w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        if (w_adv) r_rd <= mem[r_is.idx];
    end

    // bypass: the entry read this edge is the one being written this edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (w_adv) begin
            r_byp <= r_ms.valid && (r_ms.idx == r_is.idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) r_byp_val <= w_new;
    end

    // output register
    assign w_ext = {OUT_W'(0), w_new};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_ms.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_friendly <= w_new[CTR_W-1];
            r_out_value    <= w_ext[OUT_W-1:0];
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.friendly      = r_out_friendly;
    assign o_out.counter_value = r_out_value;

endmodule

@@ rtl/pchrp_checker.sv @@
module pchrp_checker import pchrp_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_out_friendly,
    input logic [OUT_W-1:0] i_out_counter_value
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_friendly) && $stable(i_out_counter_value))
        else $error("result changed while stalled");

    // friendly bit agrees with the reported counter
    a_friendly: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (CTR_W <= OUT_W) |->
            i_out_friendly == i_out_counter_value[CTR_W-1])
        else $error("friendly bit inconsistent with counter");

    // reset empties the pipeline
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // clearing pass blocks input after reset
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input ready during clearing pass");

endmodule

bind pc_hashed_reuse_predictor_top pchrp_checker u_pchrp_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_ready         (i_in.ready),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_out_friendly     (o_out.friendly),
    .i_out_counter_value(o_out.counter_value)
);

@@ tb/tb_pc_hashed_reuse_predictor_top.sv @@
`timescale 1ns / 1ps
module tb_pc_hashed_reuse_predictor_top;
    import pchrp_pkg::*;

    localparam logic OP_QUERY       = 1'b0;
    localparam logic OP_TRAIN       = 1'b1;
    localparam int   STALL_MAX      = 6;
    localparam int   WATCHDOG_LIMIT = 20000;
    localparam int   RANDOM_ITEMS   = 1100;
    localparam int   PHASE_LEN      = 50;
    localparam int   POOL_SIZE      = 8;
    localparam int   SETTLE_CYCLES  = 12;

    typedef struct {
        bit               friendly;
        bit [OUT_W-1:0]   value;
    } t_reuse_result;

    class reuse_scoreboard;
        t_ctr          counters [TABLE_ENTRIES];
        t_reuse_result pending_results [$];
        int            mismatches;

        function new();
            foreach (counters[i]) counters[i] = CTR_HALF;
            mismatches = 0;
        endfunction

        function t_idx pc_slot(logic [PC_W-1:0] pc);
            logic [PC_W-1:0] h;
            h = pc;
            repeat (HASH_STEPS) h = h[0] ? ((h >> 1) ^ CRC_POLY) : (h >> 1);
            return t_idx'(h % TABLE_ENTRIES);
        endfunction

        function void note_access(logic op, logic [PC_W-1:0] pc, logic hit);
            t_idx          idx;
            t_ctr          c;
            t_reuse_result r;
            idx = pc_slot(pc);
            c   = counters[idx];
            if (op == OP_TRAIN) begin
                if (hit) begin
                    if (c != CTR_MAX) c = c + 1'b1;
                end else if (c != '0) begin
                    c = c - 1'b1;
                end
                counters[idx] = c;
            end
            r.friendly = (c >= CTR_HALF);
            r.value    = OUT_W'(c);
            pending_results.push_back(r);
        endfunction

        function void check_result(logic friendly, logic [OUT_W-1:0] value);
            t_reuse_result r;
            if (pending_results.size() == 0) begin
                mismatches++;
                $error("unexpected result: friendly %0d counter_value %0d", friendly, value);
            end else begin
                r = pending_results.pop_front();
                if (friendly !== r.friendly) begin
                    mismatches++;
                    $error("friendly: expected %0d, actual %0d", r.friendly, friendly);
                end
                if (value !== r.value) begin
                    mismatches++;
                    $error("counter_value: expected %0d, actual %0d", r.value, value);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    pchrp_in_if  in_bus();
    pchrp_out_if out_bus();

    pc_hashed_reuse_predictor_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    reuse_scoreboard sb = new();
    bit              calm_tx;
    bit              calm_rx;
    int              idle_cycles = 0;
    logic [PC_W-1:0] pc_pool [POOL_SIZE];

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (in_bus.valid && in_bus.ready)
            sb.note_access(in_bus.operation, in_bus.pc, in_bus.opt_hit);
        if (out_bus.valid && out_bus.ready)
            sb.check_result(out_bus.friendly, out_bus.counter_value);
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random stall before each transfer, none while calm_rx is set
    initial begin
        int stall;
        out_bus.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = calm_rx ? 0 : $urandom_range(0, STALL_MAX);
            if (stall > 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_bus.ready <= 1'b1;
            do @(posedge i_clk); while (out_bus.valid !== 1'b1);
        end
    end

    task automatic send_access(logic op, logic [PC_W-1:0] pc, logic hit);
        int gap;
        gap = calm_tx ? 0 : $urandom_range(0, STALL_MAX);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.operation <= op;
        in_bus.pc        <= pc;
        in_bus.opt_hit   <= hit;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
    endtask

    task automatic drain_results();
        in_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_results.size() > 0) @(posedge i_clk);
    endtask

    initial begin
        int              hit_pct;
        int              pool_pct;
        logic [PC_W-1:0] pc;
        logic            op;

        in_bus.valid     <= 1'b0;
        in_bus.operation <= OP_QUERY;
        in_bus.pc        <= '0;
        in_bus.opt_hit   <= 1'b0;
        i_rst_n          <= 1'b0;
        calm_tx = 1'b0;
        calm_rx = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // queries ignore the outcome bit
        send_access(OP_QUERY, '0, 1'b0);
        send_access(OP_QUERY, '1, 1'b1);
        // saturate high, then low
        repeat (4) send_access(OP_TRAIN, 64'h0000_7fff_0040_1a2c, 1'b1);
        send_access(OP_QUERY, 64'h0000_7fff_0040_1a2c, 1'b1);
        repeat (5) send_access(OP_TRAIN, 64'h8000_0000_0bad_f00d, 1'b0);
        send_access(OP_QUERY, 64'h8000_0000_0bad_f00d, 1'b0);
        send_access(OP_TRAIN, '1, 1'b0);
        send_access(OP_TRAIN, '0, 1'b1);
        // back-to-back updates of one counter
        calm_tx = 1'b1;
        send_access(OP_TRAIN, 64'h0000_0000_0000_1234, 1'b1);
        send_access(OP_TRAIN, 64'h0000_0000_0000_1234, 1'b0);
        send_access(OP_TRAIN, 64'h0000_0000_0000_1234, 1'b1);
        send_access(OP_QUERY, 64'h0000_0000_0000_1234, 1'b0);
        drain_results();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_LEN == 0) begin
                calm_tx  = ($urandom_range(0, 3) == 0);
                calm_rx  = ($urandom_range(0, 3) == 0);
                hit_pct  = $urandom_range(0, 100);
                pool_pct = ($urandom_range(0, 3) == 0) ? 10 : 85;
                foreach (pc_pool[k]) pc_pool[k] = {$urandom, $urandom};
                if (n > 0 && $urandom_range(0, 3) == 0)
                    drain_results();
            end
            pc = ($urandom_range(1, 100) <= pool_pct) ?
                 pc_pool[$urandom_range(0, POOL_SIZE - 1)] : {$urandom, $urandom};
            op = ($urandom_range(0, 3) != 0) ? OP_TRAIN : OP_QUERY;
            send_access(op, pc, $urandom_range(1, 100) <= hit_pct);
        end
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/pchrp_pkg.sv
rtl/pchrp_if.sv
rtl/pc_hashed_reuse_predictor_top.sv
rtl/pchrp_checker.sv
tb/tb_pc_hashed_reuse_predictor_top.sv
